@@ sv/bdfha_pkg.sv @@
// ----------------------------------------------------------------------------
// bdfha_pkg
// Shared types, keyword tables and hex decode for the font bitmap converter.
// ----------------------------------------------------------------------------
package bdfha_pkg;

  localparam logic [7:0] CH_NL        = 8'h0a;
  localparam logic [7:0] ONE_CHAR_RST  = 8'd35;
  localparam logic [7:0] ZERO_CHAR_RST = 8'd46;
  localparam int unsigned KW_BITMAP_LEN  = 6;
  localparam int unsigned KW_ENDCHAR_LEN = 7;

  // configuration register indexes
  localparam logic REG_ONE_CHAR  = 1'b0;
  localparam logic REG_ZERO_CHAR = 1'b1;

  typedef enum logic [1:0] {
    CMD_ECHO    = 2'd0,
    CMD_PIXELS  = 2'd1,
    CMD_ENDCHAR = 2'd2
  } cmd_kind_t;

  // one request from the front to the back
  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  flush;   // held keyword bytes to show as pixels first
    logic [7:0]  ch;
  } cmd_t;

  function automatic logic [7:0] kw_endchar(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h45;  // E
      3'd1:    c = 8'h4e;  // N
      3'd2:    c = 8'h44;  // D
      3'd3:    c = 8'h43;  // C
      3'd4:    c = 8'h48;  // H
      3'd5:    c = 8'h41;  // A
      3'd6:    c = 8'h52;  // R
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_bitmap(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h42;  // B
      3'd1:    c = 8'h49;  // I
      3'd2:    c = 8'h54;  // T
      3'd3:    c = 8'h4d;  // M
      3'd4:    c = 8'h41;  // A
      3'd5:    c = 8'h50;  // P
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // returns {bad, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else begin
      r = 5'b1_0000;
    end
    return r;
  endfunction

endpackage

@@ sv/bdfha_front.sv @@
// ----------------------------------------------------------------------------
// bdfha_front
// Line parser: tracks echo/bitmap mode and keyword matches, issues requests.
// ----------------------------------------------------------------------------
module bdfha_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [7:0]        in_char,
  output logic              q_push,
  output bdfha_pkg::cmd_t   q_data,
  input  logic              q_full
);
  import bdfha_pkg::*;

  typedef enum logic [2:0] {
    MODE_ECHO    = 3'b001,
    MODE_BITMAP  = 3'b010,
    MODE_ENDLINE = 3'b100
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [2:0] match_r, match_nxt;
  logic       alive_r, alive_nxt;
  logic       pending_r, pending_nxt;
  logic       accept;
  logic       emit;
  cmd_t       cmd;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept && emit;
  assign q_data  = cmd;

  always_comb begin
    mode_nxt    = mode_r;
    match_nxt   = match_r;
    alive_nxt   = alive_r;
    pending_nxt = pending_r;
    emit        = 1'b1;
    cmd.kind    = CMD_ECHO;
    cmd.flush   = 3'd0;
    cmd.ch      = in_char;
    case (mode_r)
      MODE_BITMAP: begin
        if (alive_r && in_char == kw_endchar(match_r)) begin
          if (match_r == 3'(KW_ENDCHAR_LEN - 1)) begin
            cmd.kind  = CMD_ENDCHAR;
            mode_nxt  = MODE_ENDLINE;
            alive_nxt = 1'b0;
            match_nxt = 3'd0;
          end else begin
            // held back until the keyword is decided
            emit      = 1'b0;
            match_nxt = match_r + 3'd1;
          end
        end else begin
          cmd.flush = alive_r ? match_r : 3'd0;
          alive_nxt = 1'b0;
          match_nxt = 3'd0;
          if (in_char == CH_NL) begin
            cmd.kind    = CMD_ECHO;
            alive_nxt   = 1'b1;
            pending_nxt = 1'b0;
          end else begin
            cmd.kind = CMD_PIXELS;
          end
        end
      end
      MODE_ENDLINE: begin
        if (in_char == CH_NL) begin
          mode_nxt    = MODE_ECHO;
          match_nxt   = 3'd0;
          alive_nxt   = 1'b1;
          pending_nxt = 1'b0;
        end
      end
      default: begin
        if (in_char == CH_NL) begin
          mode_nxt    = pending_r ? MODE_BITMAP : MODE_ECHO;
          match_nxt   = 3'd0;
          alive_nxt   = 1'b1;
          pending_nxt = 1'b0;
        end else if (alive_r) begin
          if (match_r < 3'(KW_BITMAP_LEN) && in_char == kw_bitmap(match_r)) begin
            match_nxt = match_r + 3'd1;
            if (match_r == 3'(KW_BITMAP_LEN - 1)) begin
              pending_nxt = 1'b1;
              alive_nxt   = 1'b0;
            end
          end else begin
            alive_nxt = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_ECHO;
      match_r   <= 3'd0;
      alive_r   <= 1'b1;
      pending_r <= 1'b0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      match_r   <= match_nxt;
      alive_r   <= alive_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

@@ sv/bdfha_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// bdfha_cmd_fifo
// Small request queue between the line parser and the character emitter.
// ----------------------------------------------------------------------------
module bdfha_cmd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bdfha_pkg::cmd_t   wr_data,
  output logic              full,
  input  logic              pop,
  output bdfha_pkg::cmd_t   rd_data,
  output logic              empty
);
  import bdfha_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ sv/bdfha_back.sv @@
// ----------------------------------------------------------------------------
// bdfha_back
// Character emitter: expands each request into results, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module bdfha_back (
  input  logic              clk,
  input  logic              rst_n,
  input  bdfha_pkg::cmd_t   q_data,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic [7:0]        one_char,
  input  logic [7:0]        zero_char,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_char,
  output logic              out_bad_digit,
  output logic              out_last
);
  import bdfha_pkg::*;

  logic [2:0] grp_r, grp_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       bad_r, bad_nxt;
  logic       last_r, last_nxt;
  logic       advance, emit, done;
  logic [7:0] pix_src;
  logic [4:0] dec;
  logic       pix_bit;

  assign advance = !out_valid_r || out_pop;
  assign emit    = advance && !q_empty;
  assign q_pop   = emit && done;

  // pixel source is a held keyword byte while flushing, else the request byte
  assign pix_src = (grp_r < q_data.flush) ? kw_endchar(grp_r) : q_data.ch;
  assign dec     = hex_decode(pix_src);
  assign pix_bit = dec[2'd3 - idx_r[1:0]];

  always_comb begin
    grp_nxt  = grp_r;
    idx_nxt  = idx_r;
    done     = 1'b0;
    char_nxt = pix_bit ? one_char : zero_char;
    bad_nxt  = dec[4];
    last_nxt = 1'b0;
    if (grp_r < q_data.flush) begin
      if (idx_r == 3'd3) begin
        grp_nxt = grp_r + 3'd1;
        idx_nxt = 3'd0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end else begin
      case (q_data.kind)
        CMD_PIXELS: begin
          done = (idx_r == 3'd3);
        end
        CMD_ENDCHAR: begin
          char_nxt = kw_endchar(idx_r);
          bad_nxt  = 1'b0;
          done     = (idx_r == 3'(KW_ENDCHAR_LEN - 1));
        end
        default: begin
          char_nxt = q_data.ch;
          bad_nxt  = 1'b0;
          done     = 1'b1;
        end
      endcase
      last_nxt = done;
      idx_nxt  = idx_r + 3'd1;
    end
    if (done) begin
      grp_nxt = 3'd0;
      idx_nxt = 3'd0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r       <= 3'd0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        grp_r <= grp_nxt;
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_r <= char_nxt;
      bad_r  <= bad_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_empty     = !out_valid_r;
  assign out_char      = char_r;
  assign out_bad_digit = bad_r;
  assign out_last      = last_r;

endmodule

@@ sv/bdf_bitmap_hex_to_ascii_art_top.sv @@
// ----------------------------------------------------------------------------
// bdf_bitmap_hex_to_ascii_art_top
// Font text stream to pixel art converter.
// ----------------------------------------------------------------------------
// One input byte can be pushed every cycle while in_full is low; the parser
// files a request for it, unless it is held as a possible ENDCHAR prefix,
// into a FIFO_DEPTH-entry queue, and the emitter drains that queue producing
// one result per cycle while the output is popped, through a single output
// register. Echoed bytes and newlines give one result, a bitmap hex digit
// gives four, a completed ENDCHAR keyword seven, and a byte that breaks a
// held ENDCHAR prefix four per held byte plus its own. Echo text can thus
// flow at one byte per cycle. one_char and zero_char (cfg_index 0 and 1) are
// written through the cfg port, which is always ready; the user must write
// them only while the block is idle, which the block itself does not enforce.
module bdf_bitmap_hex_to_ascii_art_top #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_char,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char,
  output logic       out_bad_digit,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import bdfha_pkg::*;

  logic       one_char_we;
  logic [7:0] one_char_r;
  logic [7:0] zero_char_r;
  logic       q_push, q_full, q_pop, q_empty;
  cmd_t       q_wr_data, q_rd_data;

  assign cfg_ready   = 1'b1;
  assign one_char_we = cfg_valid && cfg_ready && (cfg_index == REG_ONE_CHAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_char_r  <= ONE_CHAR_RST;
      zero_char_r <= ZERO_CHAR_RST;
    end else if (one_char_we) begin
      one_char_r <= cfg_data;
    end else if (cfg_valid && cfg_ready && cfg_index == REG_ZERO_CHAR) begin
      zero_char_r <= cfg_data;
    end
  end

  bdfha_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_char (in_char),
    .q_push  (q_push),
    .q_data  (q_wr_data),
    .q_full  (q_full)
  );

  bdfha_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  bdfha_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_data        (q_rd_data),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .one_char      (one_char_r),
    .zero_char     (zero_char_r),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_char      (out_char),
    .out_bad_digit (out_bad_digit),
    .out_last      (out_last)
  );

endmodule

@@ sv/bdfha_checker.sv @@
// ----------------------------------------------------------------------------
// bdfha_checker
// Port-level checks for the font bitmap converter, bound to the top level.
// ----------------------------------------------------------------------------
module bdfha_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_char,
  input logic       out_bad_digit,
  input logic       out_last
);

  // reset leaves nothing to read and room to write
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result visible right after reset");

  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("queue full right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_char)
      && $stable(out_bad_digit) && $stable(out_last))
    else $error("result changed while stalled");

  // the results of one byte follow each other without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pop && !out_last |=> !out_empty)
    else $error("gap inside the results of one byte");

endmodule

bind bdf_bitmap_hex_to_ascii_art_top bdfha_checker u_bdfha_checker (.*);
